// ===== src/sahm_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sahm_pkg
// Shared types, constants and the key mixing function of the hash map.
// -----------------------------------------------------------------------------
package sahm_pkg;

   localparam int unsigned DefBuckets = 16;
   localparam int unsigned DefWays    = 4;
   localparam int unsigned KeyW       = 64;
   localparam int unsigned ValW       = 64;
   localparam int unsigned FuncW      = 2;
   localparam int unsigned BcountW    = 5;
   localparam int unsigned WaysRegW   = 3;
   localparam int unsigned AddrW      = 3;
   localparam int unsigned DataW      = 32;

   typedef enum logic [FuncW-1:0] {
      FUNC_PUT    = 2'd0,
      FUNC_GET    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_HAS    = 2'd3
   } func_type;

   localparam logic [AddrW-1:0] ADDR_BUCKETS = 3'd0;
   localparam logic [AddrW-1:0] ADDR_WAYS    = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture request, start the modulo
      logic mod_step;  // one restoring subtraction step
      logic scan;      // read way at scan index
      logic commit;    // write back and form the response
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic scan_last;
   } status_type;

   function automatic logic [KeyW-1:0] mix_key(input logic [KeyW-1:0] k);
      logic [KeyW-1:0] h;
      h = k ^ (k >> 16) ^ (k >> 12);
      h = h ^ (h >> 7) ^ (h >> 4);
      return h;
   endfunction

endpackage

// ===== src/sahm_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sahm_req_if / sahm_rsp_if
// Valid-ready channels for requests and responses of the hash map.
// -----------------------------------------------------------------------------
interface sahm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [63:0] key;
   logic [63:0] value_in;
   modport source (output valid, func, key, value_in, input ready);
   modport sink (input valid, func, key, value_in, output ready);
endinterface

interface sahm_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [63:0] value_out;
   modport source (output valid, ok, value_out, input ready);
   modport sink (input valid, ok, value_out, output ready);
endinterface

// ===== src/sahm_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sahm_ctrl
// Sequencer: modulo reduction, way scan, commit, response hand-off.
// -----------------------------------------------------------------------------
module sahm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sahm_pkg::cmd_type    cmd,
   input  sahm_pkg::status_type status
);
   import sahm_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MOD, S_SCAN, S_COMMIT} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // A request is taken only once the previous response has left.
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_done) state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== src/sahm_dp.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sahm_dp
// Datapath: hash, bit-serial modulo, slot memories and way scan.
// -----------------------------------------------------------------------------
module sahm_dp #(
   parameter int unsigned BUCKETS = sahm_pkg::DefBuckets,
   parameter int unsigned WAYS    = sahm_pkg::DefWays
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sahm_pkg::cmd_type          cmd,
   output sahm_pkg::status_type       status,
   input  logic [sahm_pkg::FuncW-1:0] req_func,
   input  logic [63:0]                req_key,
   input  logic [63:0]                req_value_in,
   input  logic [sahm_pkg::BcountW-1:0]  bucket_count,
   input  logic [sahm_pkg::WaysRegW-1:0] ways_in_use,
   output logic                       rsp_ok,
   output logic [63:0]                rsp_value_out
);
   import sahm_pkg::*;

   localparam int unsigned SLOTS = BUCKETS * WAYS;
   localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned WCW   = $clog2(WAYS + 1);
   localparam int unsigned BCW   = $clog2(BUCKETS + 1);
   localparam int unsigned CW    = 6;

   // Effective configuration, clamped to the built size; a zero is taken as one.
   logic [BCW-1:0] eff_b;
   logic [WCW-1:0] eff_w;
   always_comb begin
      if (bucket_count == '0) eff_b = BCW'(1);
      else if (32'(bucket_count) > BUCKETS) eff_b = BCW'(BUCKETS);
      else eff_b = BCW'(bucket_count);
      if (ways_in_use == '0) eff_w = WCW'(1);
      else if (32'(ways_in_use) > WAYS) eff_w = WCW'(WAYS);
      else eff_w = WCW'(ways_in_use);
   end

   logic [FuncW-1:0] func_ff;
   logic [63:0]      key_ff, val_ff, hash_ff;
   logic [BCW:0]     rem_ff;
   logic [CW-1:0]    bit_ff;
   logic [WW-1:0]    way_ff;
   logic             hit_ff, free_ff;
   logic [WW-1:0]    hit_way_ff, free_way_ff;
   logic [63:0]      hit_val_ff;
   logic             rd_pend_ff;
   logic [WW-1:0]    rd_way_ff;

   logic [SLOTS-1:0] valid_ff;
   logic [63:0]      key_mem [SLOTS];
   logic [63:0]      val_mem [SLOTS];
   logic [63:0]      key_rd, val_rd;

   // Restoring remainder, one bit of the hash a cycle from the top.
   logic [BCW:0] rem_sh, rem_in;
   assign rem_sh = {rem_ff[BCW-1:0], hash_ff[bit_ff]};
   assign rem_in = (rem_sh >= {1'b0, eff_b}) ? rem_sh - {1'b0, eff_b} : rem_sh;

   logic [BW-1:0] bucket;
   assign bucket = BW'(rem_ff);

   logic [SW-1:0] rd_slot, rd_slot_pend;
   assign rd_slot      = SW'(32'(bucket) * WAYS + 32'(way_ff));
   assign rd_slot_pend = SW'(32'(bucket) * WAYS + 32'(rd_way_ff));

   assign status.mod_done  = (bit_ff == '0);
   // Last cycle of the scan: the final read has been returned.
   assign status.scan_last = rd_pend_ff && (32'(rd_way_ff) + 1 >= 32'(eff_w));

   always_ff @(posedge clock) begin
      key_rd <= key_mem[rd_slot];
      val_rd <= val_mem[rd_slot];
   end

   logic [SW-1:0] wr_slot;
   logic          do_put, do_rem;
   assign do_put  = cmd.commit && (func_ff == FUNC_PUT) && !hit_ff && free_ff;
   assign do_rem  = cmd.commit && (func_ff == FUNC_REMOVE) && hit_ff;
   assign wr_slot = SW'(32'(bucket) * WAYS + 32'(do_put ? free_way_ff : hit_way_ff));

   always_ff @(posedge clock) begin
      if (do_put) begin
         key_mem[wr_slot] <= key_ff;
         val_mem[wr_slot] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         if (do_put) valid_ff[wr_slot] <= 1'b1;
         else if (do_rem) valid_ff[wr_slot] <= 1'b0;
         rd_pend_ff <= cmd.scan && !status.scan_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         val_ff  <= req_value_in;
         hash_ff <= mix_key(req_key);
         rem_ff  <= '0;
         bit_ff  <= CW'(63);
         way_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end
      if (cmd.mod_step) begin
         rem_ff <= rem_in;
         bit_ff <= bit_ff - CW'(1);
      end
      if (cmd.scan) begin
         rd_way_ff <= way_ff;
         if (32'(way_ff) + 1 < WAYS) way_ff <= way_ff + WW'(1);
         if (rd_pend_ff) begin
            if (valid_ff[rd_slot_pend]) begin
               if (!hit_ff && key_rd == key_ff) begin
                  hit_ff     <= 1'b1;
                  hit_way_ff <= rd_way_ff;
                  hit_val_ff <= val_rd;
               end
            end else if (!free_ff) begin
               free_ff     <= 1'b1;
               free_way_ff <= rd_way_ff;
            end
         end
      end
      if (cmd.commit) begin
         case (func_ff)
            FUNC_PUT:    rsp_ok <= hit_ff || free_ff;
            FUNC_GET,
            FUNC_REMOVE,
            FUNC_HAS:    rsp_ok <= hit_ff;
            default:     rsp_ok <= 1'b0;
         endcase
         rsp_value_out <= (hit_ff && (func_ff == FUNC_GET || func_ff == FUNC_REMOVE))
                          ? hit_val_ff : '0;
      end
   end
endmodule

// ===== src/set_assoc_hash_map.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// set_assoc_hash_map
// Set-associative key-value map with put, get, remove and has.
// -----------------------------------------------------------------------------
// Each request runs a bit-serial reduction of all 64 bits of the mixed key
// modulo the bucket count, one bit a cycle, then a scan of each way in use
// through the registered memory read, then a commit. One request is in
// flight at a time; a new one is taken once the previous response has been
// accepted.
module set_assoc_hash_map #(
   parameter int unsigned BUCKETS = sahm_pkg::DefBuckets,
   parameter int unsigned WAYS    = sahm_pkg::DefWays
) (
   input  logic                       clock,
   input  logic                       reset,
   sahm_req_if.sink                   req,
   sahm_rsp_if.source                 rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [sahm_pkg::AddrW-1:0] csr_paddr,
   input  logic [sahm_pkg::DataW-1:0] csr_pwdata,
   output logic [sahm_pkg::DataW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import sahm_pkg::*;

   logic [BcountW-1:0]  bcount_ff;
   logic [WaysRegW-1:0] ways_ff;
   cmd_type             cmd;
   status_type          status;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= BcountW'(16);
         ways_ff   <= WaysRegW'(1);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            ADDR_BUCKETS: bcount_ff <= csr_pwdata[BcountW-1:0];
            ADDR_WAYS:    ways_ff   <= csr_pwdata[WaysRegW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_BUCKETS: csr_prdata = DataW'(bcount_ff);
         ADDR_WAYS:    csr_prdata = DataW'(ways_ff);
         default:      csr_prdata = '0;
      endcase
   end

   sahm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sahm_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req.func),
      .req_key       (req.key),
      .req_value_in  (req.value_in),
      .bucket_count  (bcount_ff),
      .ways_in_use   (ways_ff),
      .rsp_ok        (rsp.ok),
      .rsp_value_out (rsp.value_out)
   );

   // A load and a commit never coincide.
   a_load_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.commit)) else $error("load and commit together");

   // A commit raises the response valid in the next cycle.
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp.valid) else $error("commit without response");

   // No new request while a response waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("request taken during response");
endmodule
